@@ hdl/sorted_key_slot_table_macros.svh @@
// Assertion macros shared by the sorted key slot table RTL.
`ifndef SORTED_KEY_SLOT_TABLE_MACROS_SVH
`define SORTED_KEY_SLOT_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/skt_pkg.sv @@
// Package: sizes, codes and entry type of the sorted key slot table.
package skt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;

  // Port widths fixed by the interface.
  localparam int KEY_PORT_W = 32;
  localparam int RIX_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int CMD_W      = 2;
  localparam int OUT_SLOT_W = 6;

  // Derived sizes.
  localparam int KEY_BITS = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int ADDR_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_W   = ADDR_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP     = 2'd0,
    CMD_DEFINE     = 2'd1,
    CMD_DEACTIVATE = 2'd2,
    CMD_RSVD       = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_HIT     = 3'd0,
    STS_MISS    = 3'd1,
    STS_ADDED   = 3'd2,
    STS_UPDATED = 3'd3,
    STS_FULL    = 3'd4
  } status_e;

  // One row of the sorted array.
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [SLOT_W-1:0]   slot;
  } entry_t;

endpackage

@@ hdl/sorted_key_slot_table.sv @@
// Top level: sorted key table with binary search, in-order insert and slot binding.
//
// Input channel: in_valid_i / in_stall_o carry a request (command_i, key_i,
// runtime_index_i). A request is taken when in_valid_i is high and in_stall_o
// is low; in_stall_o is high while a request is being worked on.
// Output channel: out_valid_o / out_stall_i carry one result per request
// (status_o, slot_o, slot_runtime_index_o, slot_active_o).
// Work per command from accept to result shown:
//   deactivate-all or reserved command: straight to the output register
//   lookup: p probes, at most ceil(log2(n+1)) for n keys held, each probe
//     issuing a sorted-key memory read and comparing its registered data;
//     a define of an absent key into a full table ends the same way
//   define of a present key: the search only; of an absent key: the search,
//     then one entry moved up per cycle through the sorted-key memory down
//     to the insert point, then the new key is written and its slot bound.
// One request is worked on at a time; the next is taken as soon as the
// result sits in the output register, even if the receiver still stalls it.
// A stalled result holds; a finished request waits in its last state until
// the output register is free.
// Reset clears the key count and all active marks; the memories need no
// clearing pass, since only entries below the count are ever read.
`include "sorted_key_slot_table_macros.svh"

module sorted_key_slot_table
  import skt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [KEY_PORT_W-1:0] key_i,
  input  logic [RIX_W-1:0]      runtime_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [OUT_SLOT_W-1:0] slot_o,
  output logic [RIX_W-1:0]      slot_runtime_index_o,
  output logic                  slot_active_o
);

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a request
    ST_SRCH,   // issue probe read or finish search
    ST_CMP,    // compare probe data
    ST_LKRES,  // lookup hit: runtime index read returns
    ST_SHIFT,  // move entries up one place
    ST_INS,    // write the new key, bind its slot
    ST_RESP    // hand result to the output register
  } state_e;

  // Memories: sorted keys with slot numbers, and runtime index per slot.
  entry_t           key_mem [TABLE_DEPTH];
  logic [RIX_W-1:0] rt_mem  [TABLE_DEPTH];

  entry_t            key_rd_q;
  logic [ADDR_W-1:0] key_raddr;
  logic              key_we;
  logic [ADDR_W-1:0] key_waddr;
  entry_t            key_wdata;

  logic [RIX_W-1:0]  rt_rd_q;
  logic [ADDR_W-1:0] rt_raddr;
  logic              rt_we;
  logic [ADDR_W-1:0] rt_waddr;

  // Control and working registers.
  state_e                state_q;
  logic [CNT_W-1:0]      count_q;
  logic [TABLE_DEPTH-1:0] active_q;
  cmd_e                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [RIX_W-1:0]      rix_q;
  logic [CNT_W-1:0]      lo_q, hi_q, idx_q;
  logic [ADDR_W-1:0]     mid_q;
  logic                  pend_q;
  logic [ADDR_W-1:0]     pend_addr_q;
  logic [SLOT_W-1:0]     res_slot_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [RIX_W-1:0]      res_rt_q;
  logic                  res_act_q;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [OUT_SLOT_W-1:0] out_slot_q;
  logic [RIX_W-1:0]      out_rt_q;
  logic                  out_act_q;

  logic [CNT_W:0]        mid_sum;
  logic [ADDR_W-1:0]     mid;
  logic [ADDR_W-1:0]     new_slot;
  logic                  out_free;
  logic [31:0]           slot_ext;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[ADDR_W:1];
  assign new_slot = count_q[ADDR_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign slot_ext = 32'(res_slot_q);

  assign in_stall_o           = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign slot_o               = out_slot_q;
  assign slot_runtime_index_o = out_rt_q;
  assign slot_active_o        = out_act_q;

  // Memory port control.
  always_comb begin
    key_raddr = mid;
    key_we    = 1'b0;
    key_waddr = pend_addr_q;
    key_wdata = key_rd_q;
    rt_raddr  = key_rd_q.slot;
    rt_we     = 1'b0;
    rt_waddr  = new_slot;
    unique case (state_q)
      ST_SHIFT: begin
        key_raddr = ADDR_W'(idx_q - CNT_W'(1));
        key_we    = pend_q;
      end
      ST_INS: begin
        key_we         = 1'b1;
        key_waddr      = lo_q[ADDR_W-1:0];
        key_wdata.key  = key_q;
        key_wdata.slot = new_slot;
        rt_we          = 1'b1;
      end
      ST_CMP: begin
        if (key_q == key_rd_q.key && cmd_q == CMD_DEFINE) begin
          rt_we    = 1'b1;
          rt_waddr = key_rd_q.slot;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rd_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rt_we) begin
      rt_mem[rt_waddr] <= rix_q;
    end
    rt_rd_q <= rt_mem[rt_raddr];
  end

  // Sequencer, state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      active_q     <= '0;
      cmd_q        <= CMD_LOOKUP;
      key_q        <= '0;
      rix_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      idx_q        <= '0;
      mid_q        <= '0;
      pend_q       <= 1'b0;
      pend_addr_q  <= '0;
      res_slot_q   <= '0;
      res_status_q <= STS_MISS;
      res_rt_q     <= '0;
      res_act_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= STS_MISS;
      out_slot_q   <= '0;
      out_rt_q     <= '0;
      out_act_q    <= 1'b0;
    end else begin
      // In ST_RESP the output register is reloaded instead.
      if (out_valid_q && !out_stall_i && state_q != ST_RESP) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q      <= cmd_e'(command_i);
            key_q      <= key_i[KEY_BITS-1:0];
            rix_q      <= runtime_index_i;
            lo_q       <= '0;
            hi_q       <= count_q;
            res_slot_q <= '0;
            res_rt_q   <= '0;
            res_act_q  <= 1'b0;
            unique case (cmd_e'(command_i)) inside
              CMD_LOOKUP, CMD_DEFINE: begin
                state_q <= ST_SRCH;
              end
              CMD_DEACTIVATE: begin
                // Runtime indices read as zero once the mark is clear.
                active_q     <= '0;
                res_status_q <= STS_HIT;
                state_q      <= ST_RESP;
              end
              default: begin
                res_status_q <= STS_MISS;
                state_q      <= ST_RESP;
              end
            endcase
          end
        end
        ST_SRCH: begin
          if (lo_q < hi_q) begin
            mid_q   <= mid;
            state_q <= ST_CMP;
          end else if (cmd_q != CMD_DEFINE) begin
            res_status_q <= STS_MISS;
            state_q      <= ST_RESP;
          end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
            res_status_q <= STS_FULL;
            state_q      <= ST_RESP;
          end else begin
            idx_q   <= count_q;
            pend_q  <= 1'b0;
            state_q <= ST_SHIFT;
          end
        end
        ST_CMP: begin
          if (key_q == key_rd_q.key) begin
            res_slot_q <= key_rd_q.slot;
            if (cmd_q == CMD_DEFINE) begin
              active_q[key_rd_q.slot] <= 1'b1;
              res_status_q <= STS_UPDATED;
              res_rt_q     <= rix_q;
              res_act_q    <= 1'b1;
              state_q      <= ST_RESP;
            end else begin
              state_q <= ST_LKRES;
            end
          end else if (key_q < key_rd_q.key) begin
            hi_q    <= CNT_W'(mid_q);
            state_q <= ST_SRCH;
          end else begin
            lo_q    <= CNT_W'(mid_q) + CNT_W'(1);
            state_q <= ST_SRCH;
          end
        end
        ST_LKRES: begin
          res_status_q <= STS_HIT;
          res_act_q    <= active_q[res_slot_q];
          res_rt_q     <= active_q[res_slot_q] ? rt_rd_q : '0;
          state_q      <= ST_RESP;
        end
        ST_SHIFT: begin
          // Read entry idx-1 now, write it to idx next cycle.
          if (idx_q > lo_q) begin
            pend_q      <= 1'b1;
            pend_addr_q <= idx_q[ADDR_W-1:0];
            idx_q       <= idx_q - CNT_W'(1);
          end else begin
            pend_q  <= 1'b0;
            state_q <= ST_INS;
          end
        end
        ST_INS: begin
          active_q[new_slot] <= 1'b1;
          count_q      <= count_q + CNT_W'(1);
          res_slot_q   <= new_slot;
          res_status_q <= STS_ADDED;
          res_rt_q     <= rix_q;
          res_act_q    <= 1'b1;
          state_q      <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= slot_ext[OUT_SLOT_W-1:0];
            out_rt_q     <= res_rt_q;
            out_act_q    <= res_act_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `SKT_ASSERT_NOW(a_shift_not_below_pos, state_q == ST_SHIFT, idx_q >= lo_q,
                  "shift index fell below the insert point")
  `SKT_ASSERT_NEXT(a_count_only_on_insert, state_q != ST_INS, count_q == $past(count_q),
                   "key count changed outside an insert")
  `SKT_ASSERT_NOW(a_no_pending_move_idle, state_q == ST_IDLE, !pend_q,
                  "entry move left pending after a request")
  `SKT_ASSERT_NEXT(a_result_loaded, state_q == ST_RESP && out_free, out_valid_q,
                   "finished request did not reach the output register")

endmodule

@@ tb/sv/sorted_key_slot_table_tb.sv @@
// Self-checking testbench for the sorted key slot table: directed rows, then random requests.
`timescale 1ns / 1ps

module sorted_key_slot_table_tb;
  import skt_pkg::*;

  // Run length and pacing.
  localparam int RANDOM_REQS  = 600;
  localparam int QUIET_FROM   = 500;     // no idling on either side from here on
  localparam int POOL_SIZE    = 80;      // a bit over TABLE_DEPTH so the table fills
  localparam int HOLD_AFTER   = 150;     // results seen before the long receiver hold
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  // One result as the block presents it.
  typedef struct {
    status_e               status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [RIX_W-1:0]      rix;
    logic                  active;
  } answer_t;

  // One row of the directed table; the answer fields only count when typed is set.
  typedef struct packed {
    cmd_e                  cmd;
    logic [KEY_PORT_W-1:0] key;
    logic [RIX_W-1:0]      rix;
    logic                  typed;
    status_e               exp_status;
    logic [OUT_SLOT_W-1:0] exp_slot;
    logic [RIX_W-1:0]      exp_rix;
    logic                  exp_active;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;

  // Typed answers: empty table, command three, deactivate-all, and the first
  // three inserts (slots are handed out in order of first definition).
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_LOOKUP,     32'h0000_0000, 16'h0000, 1'b1, STS_MISS,  6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'hFFFF_FFFF, 16'hFFFF, 1'b1, STS_MISS,  6'd0, 16'h0000, 1'b0},
    '{CMD_RSVD,       32'h0000_1234, 16'h4321, 1'b1, STS_MISS,  6'd0, 16'h0000, 1'b0},
    '{CMD_DEACTIVATE, 32'hDEAD_BEEF, 16'hFFFF, 1'b1, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_DEFINE,     32'h8000_0000, 16'h1234, 1'b1, STS_ADDED, 6'd0, 16'h1234, 1'b1},
    '{CMD_DEFINE,     32'hFFFF_FFFF, 16'hFFFF, 1'b1, STS_ADDED, 6'd1, 16'hFFFF, 1'b1},
    '{CMD_DEFINE,     32'h0000_0000, 16'h0000, 1'b1, STS_ADDED, 6'd2, 16'h0000, 1'b1},
    '{CMD_DEFINE,     32'h7FFF_FFFF, 16'hAAAA, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_DEFINE,     32'h8000_0001, 16'h5555, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_DEFINE,     32'hFFFF_FFFE, 16'h8001, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_DEFINE,     32'h0000_0001, 16'h7FFE, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'h0000_0000, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'hFFFF_FFFF, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'h8000_0000, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'h4000_0000, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_DEFINE,     32'h8000_0000, 16'hBEEF, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_RSVD,       32'h8000_0000, 16'h0001, 1'b1, STS_MISS,  6'd0, 16'h0000, 1'b0},
    '{CMD_DEACTIVATE, 32'h0000_0000, 16'h0000, 1'b1, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'h8000_0000, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'h0000_0000, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_DEFINE,     32'hFFFF_FFFF, 16'h0001, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'hFFFF_FFFF, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'h7FFF_FFFF, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_DEFINE,     32'h7FFF_FFFF, 16'hFFFF, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0},
    '{CMD_LOOKUP,     32'hFFFF_FFFD, 16'h0000, 1'b0, STS_HIT,   6'd0, 16'h0000, 1'b0}
  };

  // Clock, reset and DUT ports; every input is known from time zero.
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cmd_e                  req_cmd = CMD_LOOKUP;
  logic [KEY_PORT_W-1:0] req_key = '0;
  logic [RIX_W-1:0]      req_rix = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [OUT_SLOT_W-1:0] slot;
  logic [RIX_W-1:0]      slot_rix;
  logic                  slot_active;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_key_slot_table dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .command_i            (req_cmd),
    .key_i                (req_key),
    .runtime_index_i      (req_rix),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .status_o             (status),
    .slot_o               (slot),
    .slot_runtime_index_o (slot_rix),
    .slot_active_o        (slot_active)
  );

  // ---------------------------------------------------------------------------
  // Table mirror: sorted keys with their slots, and per-slot runtime index and
  // active mark. Only entries below mirror_count are ever read.
  // ---------------------------------------------------------------------------
  logic [KEY_PORT_W-1:0] mirror_keys  [TABLE_DEPTH];
  logic [OUT_SLOT_W-1:0] mirror_slots [TABLE_DEPTH];
  logic [RIX_W-1:0]      slot_rix_of  [TABLE_DEPTH];
  logic                  slot_live    [TABLE_DEPTH];
  int                    mirror_count = 0;

  answer_t answers_due [$];   // one per accepted request, oldest first
  int      mismatches   = 0;
  int      results_seen = 0;
  int      cycle_count  = 0;
  bit      quiet        = 1'b0;

  initial begin
    foreach (slot_live[i]) slot_live[i] = 1'b0;
  end

  // Binary search over the mirror; pos is the match or the insert point.
  function automatic bit find_key(input logic [KEY_PORT_W-1:0] k, output int pos);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = mirror_count;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (k < mirror_keys[mid]) begin
        hi = mid;
      end else if (k > mirror_keys[mid]) begin
        lo = mid + 1;
      end else begin
        pos = mid;
        return 1'b1;
      end
    end
    pos = lo;
    return 1'b0;
  endfunction

  // Applies one request to the mirror and returns the answer it should give.
  function automatic answer_t table_answer(input cmd_e c, input logic [KEY_PORT_W-1:0] k,
                                           input logic [RIX_W-1:0] r);
    answer_t a;
    int      pos;
    int      s;
    a.status = STS_MISS;
    a.slot   = '0;
    a.rix    = '0;
    a.active = 1'b0;
    case (c)
      CMD_LOOKUP: begin
        if (find_key(k, pos)) begin
          s        = int'(mirror_slots[pos]);
          a.status = STS_HIT;
          a.slot   = OUT_SLOT_W'(s);
          a.rix    = slot_rix_of[s];
          a.active = slot_live[s];
        end
      end
      CMD_DEFINE: begin
        if (find_key(k, pos)) begin
          s           = int'(mirror_slots[pos]);
          a.status    = STS_UPDATED;
        end else if (mirror_count >= TABLE_DEPTH) begin
          s           = -1;
          a.status    = STS_FULL;
        end else begin
          // Insert in order: higher entries move up one place.
          s = mirror_count;
          for (int i = mirror_count; i > pos; i--) begin
            mirror_keys[i]  = mirror_keys[i-1];
            mirror_slots[i] = mirror_slots[i-1];
          end
          mirror_keys[pos]  = k;
          mirror_slots[pos] = OUT_SLOT_W'(s);
          mirror_count++;
          a.status = STS_ADDED;
        end
        if (s >= 0) begin
          slot_rix_of[s] = r;
          slot_live[s]   = 1'b1;
          a.slot         = OUT_SLOT_W'(s);
          a.rix          = r;
          a.active       = 1'b1;
        end
      end
      CMD_DEACTIVATE: begin
        for (int i = 0; i < mirror_count; i++) begin
          slot_rix_of[i] = '0;
          slot_live[i]   = 1'b0;
        end
        a.status = STS_HIT;
      end
      default: ;  // command three leaves the table alone
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Payload changes at the falling edge; acceptance is seen at
  // the rising edge with in_stall low. Valid stays high across back-to-back
  // requests, so it gets at most one assignment per step.
  // ---------------------------------------------------------------------------
  task automatic send_request(input cmd_e c, input logic [KEY_PORT_W-1:0] k,
                              input logic [RIX_W-1:0] r, input bit typed,
                              input answer_t typed_answer);
    int      gap;
    answer_t a;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    req_cmd  <= c;
    req_key  <= k;
    req_rix  <= r;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    // Accepted at this edge: advance the mirror now, in acceptance order.
    a = table_answer(c, k, r);
    answers_due.push_back(typed ? typed_answer : a);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, calm stretches, and one long hold that
  // lets the block fill its output register and then stall its input.
  // ---------------------------------------------------------------------------
  initial begin
    bit hold_done;
    int hold_count;
    hold_done = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (!quiet && !hold_done && results_seen >= HOLD_AFTER) begin
        out_stall  <= 1'b1;
        hold_count = 0;
        while (hold_count < HOLD_CYCLES) begin
          @(negedge clk_i);
          hold_count++;
        end
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
    end
  endtask

  // Compare each accepted result against the oldest answer due.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_valid === 1'b1 && !out_stall) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d: no request outstanding, got status %0h", results_seen,
                   status);
      end else begin
        want = answers_due.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("slot", 32'(want.slot), 32'(slot));
        check_field("slot_runtime_index", 32'(want.rix), 32'(slot_rix));
        check_field("slot_active", 32'(want.active), 32'(slot_active));
      end
      results_seen++;
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("sorted_key_slot_table: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];
    answer_t               typed_answer;
    cmd_e                  c;
    logic [KEY_PORT_W-1:0] k;
    int                    pick;

    // Pool: extremes, runs of adjacent keys, and scattered random ones.
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    for (int i = 3; i < POOL_SIZE; i++)
      key_pool[i] = (i % 4 == 0) ? key_pool[i-1] + 1 : $urandom();

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) begin
      typed_answer.status = DIRECTED[i].exp_status;
      typed_answer.slot   = DIRECTED[i].exp_slot;
      typed_answer.rix    = DIRECTED[i].exp_rix;
      typed_answer.active = DIRECTED[i].exp_active;
      send_request(DIRECTED[i].cmd, DIRECTED[i].key, DIRECTED[i].rix, DIRECTED[i].typed,
                   typed_answer);
    end

    // Random part: mostly defines and lookups on pooled keys, so the table
    // fills partway through and the full case keeps coming up afterwards.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n >= QUIET_FROM) quiet = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45)      c = CMD_DEFINE;
      else if (pick < 88) c = CMD_LOOKUP;
      else if (pick < 94) c = CMD_DEACTIVATE;
      else                c = CMD_RSVD;
      k = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                      : $urandom();
      send_request(c, k, RIX_W'($urandom_range(0, 65535)), 1'b0, typed_answer);
    end

    @(negedge clk_i);
    in_valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("sorted_key_slot_table: match");
    end else begin
      $display("sorted_key_slot_table: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/skt_pkg.sv
hdl/sorted_key_slot_table.sv
tb/sv/sorted_key_slot_table_tb.sv
